// ===== rtl/dsfp_pkg.sv =====
// Shared types and constants of the particulate sensor frame parser.
package dsfp_pkg;

  // Header bytes that open every frame
  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;

  // Payload geometry
  localparam int unsigned IDX_W          = 5;
  localparam logic [15:0] MIN_LENGTH     = 16'd28;
  localparam logic [IDX_W-1:0] SUMMED_LAST = 5'd25;
  localparam logic [IDX_W-1:0] CHECK_HIGH_IDX = 5'd26;
  localparam logic [IDX_W-1:0] LAST_IDX  = 5'd27;

  // Payload offsets of the big-endian atmospheric PM words
  localparam logic [IDX_W-1:0] PM1_OFFSET  = 5'd6;
  localparam logic [IDX_W-1:0] PM25_OFFSET = 5'd8;
  localparam logic [IDX_W-1:0] PM10_OFFSET = 5'd10;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_SHORT   = 2'd2
  } status_t;

endpackage

// ===== rtl/dust_sensor_frame_parser.sv =====
// Particulate sensor serial frame parser: input register, parser logic, result register.

// The parser takes one received byte per clock and returns a result word for
// every frame that ends (valid, checksum mismatch or short length field).
// Each byte passes an input register and then, if it closes a frame, the
// result register, which drives the outputs. Bytes are accepted back to back
// at one per cycle; the input side stalls only while a result waits in the
// result register and the next byte would produce another one. parser_enable
// resets to 0 and is set through cfg_write/cfg_data; while it is low bytes are
// dropped and the parser returns to hunting for the header.
module dust_sensor_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pm1_value,
  output logic [15:0] pm25_value,
  output logic [15:0] pm10_value,
  output logic [1:0]  frame_status,
  output logic        first_valid
);

  logic                          parser_enable;
  logic                          byte_valid;
  logic [7:0]                    byte_q;
  dsfp_pkg::phase_t              phase;
  dsfp_pkg::phase_t              phase_next;
  logic [dsfp_pkg::IDX_W-1:0]    payload_index;
  logic [dsfp_pkg::IDX_W-1:0]    payload_index_next;
  logic [15:0]                   running_sum;
  logic [15:0]                   running_sum_next;
  logic [7:0]                    length_high;
  logic [7:0]                    length_high_next;
  logic [15:0]                   captured_pm [3];
  logic [15:0]                   captured_pm_next [3];
  logic [7:0]                    check_high;
  logic [7:0]                    check_high_next;
  logic                          sensor_seen;
  logic                          sensor_seen_next;

  logic                          emit;
  logic [15:0]                   res_pm1;
  logic [15:0]                   res_pm25;
  logic [15:0]                   res_pm10;
  dsfp_pkg::status_t             res_status;
  logic                          res_first;
  logic                          out_free;
  logic                          advance;

  // Move the held word on unless it makes a result with no room for it
  assign out_free = !out_valid || !out_stall;
  assign advance  = byte_valid && (!emit || out_free);
  assign in_stall = byte_valid && !advance;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      parser_enable <= 1'b0;
    end else if (cfg_write) begin
      parser_enable <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= rx_byte;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (!parser_enable) begin
      phase_next = dsfp_pkg::PH_HUNT1;
    end else begin
      unique case (phase)
        dsfp_pkg::PH_HUNT1: begin
          if (byte_q == dsfp_pkg::HDR_FIRST) phase_next = dsfp_pkg::PH_HUNT2;
        end
        dsfp_pkg::PH_HUNT2: begin
          phase_next = (byte_q == dsfp_pkg::HDR_SECOND) ? dsfp_pkg::PH_LEN_HI
                                                        : dsfp_pkg::PH_HUNT1;
        end
        dsfp_pkg::PH_LEN_HI: begin
          phase_next = dsfp_pkg::PH_LEN_LO;
        end
        dsfp_pkg::PH_LEN_LO: begin
          phase_next = ({length_high, byte_q} < dsfp_pkg::MIN_LENGTH) ?
                       dsfp_pkg::PH_HUNT1 : dsfp_pkg::PH_PAYLOAD;
        end
        dsfp_pkg::PH_PAYLOAD: begin
          if (payload_index == dsfp_pkg::LAST_IDX) phase_next = dsfp_pkg::PH_HUNT1;
        end
        default: phase_next = dsfp_pkg::PH_HUNT1;
      endcase
    end
  end

  // Frame datapath and result
  always_comb begin
    payload_index_next  = payload_index;
    running_sum_next    = running_sum;
    length_high_next    = length_high;
    captured_pm_next    = captured_pm;
    check_high_next     = check_high;
    sensor_seen_next    = sensor_seen;
    emit                = 1'b0;
    res_pm1             = 16'h0000;
    res_pm25            = 16'h0000;
    res_pm10            = 16'h0000;
    res_status          = dsfp_pkg::ST_VALID;
    res_first           = 1'b0;
    if (parser_enable) begin
      unique case (phase)
        dsfp_pkg::PH_LEN_HI: begin
          length_high_next = byte_q;
        end
        dsfp_pkg::PH_LEN_LO: begin
          if ({length_high, byte_q} < dsfp_pkg::MIN_LENGTH) begin
            emit       = 1'b1;
            res_status = dsfp_pkg::ST_SHORT;
          end else begin
            running_sum_next   = {8'h00, dsfp_pkg::HDR_FIRST} + {8'h00, dsfp_pkg::HDR_SECOND}
                               + {8'h00, length_high} + {8'h00, byte_q};
            payload_index_next = '0;
          end
        end
        dsfp_pkg::PH_PAYLOAD: begin
          // Sum the leading payload bytes
          if (payload_index <= dsfp_pkg::SUMMED_LAST) begin
            running_sum_next = running_sum + {8'h00, byte_q};
          end
          // Capture the PM words, high byte first
          unique case (payload_index)
            dsfp_pkg::PM1_OFFSET:
              captured_pm_next[0] = {byte_q, 8'h00};
            dsfp_pkg::PM1_OFFSET + 5'd1:
              captured_pm_next[0] = captured_pm[0] | {8'h00, byte_q};
            dsfp_pkg::PM25_OFFSET:
              captured_pm_next[1] = {byte_q, 8'h00};
            dsfp_pkg::PM25_OFFSET + 5'd1:
              captured_pm_next[1] = captured_pm[1] | {8'h00, byte_q};
            dsfp_pkg::PM10_OFFSET:
              captured_pm_next[2] = {byte_q, 8'h00};
            dsfp_pkg::PM10_OFFSET + 5'd1:
              captured_pm_next[2] = captured_pm[2] | {8'h00, byte_q};
            default: ;
          endcase
          if (payload_index == dsfp_pkg::CHECK_HIGH_IDX) begin
            check_high_next = byte_q;
          end
          // Close the frame on the last byte
          if (payload_index == dsfp_pkg::LAST_IDX) begin
            emit               = 1'b1;
            payload_index_next = '0;
            if ({check_high, byte_q} != running_sum) begin
              res_status = dsfp_pkg::ST_BAD_SUM;
            end else begin
              res_pm1          = captured_pm[0];
              res_pm25         = captured_pm[1];
              res_pm10         = captured_pm[2];
              res_first        = !sensor_seen;
              sensor_seen_next = 1'b1;
            end
          end else begin
            payload_index_next = payload_index + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Parser state, updated as each word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= dsfp_pkg::PH_HUNT1;
      payload_index  <= '0;
      running_sum    <= 16'h0000;
      length_high    <= 8'h00;
      captured_pm[0] <= 16'h0000;
      captured_pm[1] <= 16'h0000;
      captured_pm[2] <= 16'h0000;
      check_high     <= 8'h00;
      sensor_seen    <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      payload_index  <= payload_index_next;
      running_sum    <= running_sum_next;
      length_high    <= length_high_next;
      captured_pm    <= captured_pm_next;
      check_high     <= check_high_next;
      sensor_seen    <= sensor_seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && emit) begin
      pm1_value    <= res_pm1;
      pm25_value   <= res_pm25;
      pm10_value   <= res_pm10;
      frame_status <= res_status;
      first_valid  <= res_first;
    end
  end

`ifndef SYNTHESIS
  // A failed frame carries no concentrations
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status != dsfp_pkg::ST_VALID |->
      pm1_value == 16'h0000 && pm25_value == 16'h0000 && pm10_value == 16'h0000
      && !first_valid)
    else $error("failed frame result carries data");

  // The first-valid flag is shown only once the sensor has been marked seen
  assert property (@(posedge clk) disable iff (rst)
    out_valid && first_valid |-> sensor_seen)
    else $error("first_valid without sensor_seen");

  // A word that closes a frame never overwrites a waiting result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && byte_valid && emit |=> out_valid && $stable(frame_status))
    else $error("waiting result lost");
`endif

endmodule
